### hdl/mpab_pkg.sv
// shared types and constants for the multi-pattern automaton builder
// no dependencies; used by multi_pattern_automaton_builder_top

package mpab_pkg;

   localparam int FIELD_W = 10;
   localparam int DEF_ALPHABET = 26;
   localparam int DEF_MAX_NODES = 1024;
   localparam logic [FIELD_W-1:0] LEN_MAX = 10'd1023;

   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [4:0]         char_code;
      logic               last_char;
      logic [FIELD_W-1:0] node_select;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] node_index;
      logic [FIELD_W-1:0] suffix_link;
      logic               has_suffix_link;
      logic [FIELD_W-1:0] terminal_link;
      logic               has_terminal_link;
      logic               is_terminal;
      logic [FIELD_W-1:0] pattern_length;
      logic [FIELD_W-1:0] child;
      logic               has_child;
      logic               table_full;
   } rsp_type;

endpackage

### hdl/mpab_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module mpab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/multi_pattern_automaton_builder_top.sv
// top level of the multi-pattern automaton builder: trie insert, link build, node read
// depends on mpab_pkg and mpab_ram (child rows, node words, breadth-first queue)
//
//   channel   direction   ports                                payload
//   req       in          req_valid, req_stall, req_data       mpab_pkg::req_type
//   rsp       out         rsp_valid, rsp_stall, rsp_data       mpab_pkg::rsp_type
//
// steps: a letter reads the cursor's row, then moves to an existing child, allocates a node
// (writing the row and the new node word, then clearing the new row) or marks an existing
// child terminal by rewriting its word; a read fetches row and word together; op 3,
// out-of-range letters and reads beyond the table answer with no ram read. build scans
// each node's row breadth first, walks the suffix chain per child and rewrites its word.
// reset: one cycle after reset clears the root row and root node word; req_stall is high.
// a stalled rsp holds the next result in its state; req_stall is high whenever an item
// is in work, and low in idle even while a finished transfer waits on rsp.

module multi_pattern_automaton_builder_top #(
   parameter int ALPHABET  = mpab_pkg::DEF_ALPHABET,
   parameter int MAX_NODES = mpab_pkg::DEF_MAX_NODES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpab_pkg::rsp_type rsp_data
);

   localparam int FW     = mpab_pkg::FIELD_W;
   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int CNT_W  = NODE_W + 1;
   localparam int CHAR_W = $clog2(ALPHABET);
   localparam int SCAN_W = CHAR_W + 1;
   localparam int ROW_W  = ALPHABET * NODE_W;
   localparam int SEL_W  = (CNT_W > FW) ? CNT_W : FW;

   // node word layout
   localparam int FLAG_BIT = FW;
   localparam int TL_LSB   = FW + 1;
   localparam int TL_HAS   = TL_LSB + NODE_W;
   localparam int SL_LSB   = TL_HAS + 1;
   localparam int SL_HAS   = SL_LSB + NODE_W;
   localparam int NW       = SL_HAS + 1;

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_C_ROW   = 4'd2;
   localparam logic [3:0] S_C_CLR   = 4'd3;
   localparam logic [3:0] S_C_TERM  = 4'd4;
   localparam logic [3:0] S_R_DATA  = 4'd5;
   localparam logic [3:0] S_B_START = 4'd6;
   localparam logic [3:0] S_B_POP   = 4'd7;
   localparam logic [3:0] S_B_U1    = 4'd8;
   localparam logic [3:0] S_B_U2    = 4'd9;
   localparam logic [3:0] S_B_SCAN  = 4'd10;
   localparam logic [3:0] S_B_L     = 4'd11;
   localparam logic [3:0] S_B_S     = 4'd12;
   localparam logic [3:0] S_B_SD    = 4'd13;
   localparam logic [3:0] S_B_V     = 4'd14;
   localparam logic [3:0] S_EMIT    = 4'd15;

   logic [3:0]        state_ff, state_in;
   mpab_pkg::req_type req_ff, req_in;
   mpab_pkg::rsp_type res_ff, res_in;
   mpab_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [FW-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [NODE_W-1:0] new_node_ff, new_node_in;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic [ROW_W-1:0]  row_u_ff, row_u_in;
   logic              slu_has_ff, slu_has_in;
   logic [NODE_W-1:0] slu_ff, slu_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [NODE_W-1:0] s_ff, s_in;
   logic              tl_has_ff, tl_has_in;
   logic [NODE_W-1:0] tl_ff, tl_in;

   logic              row_we;
   logic [NODE_W-1:0] row_waddr, row_raddr;
   logic [ROW_W-1:0]  row_wdata, row_rd;
   logic              node_we;
   logic [NODE_W-1:0] node_waddr, node_raddr;
   logic [NW-1:0]     node_wdata, node_rd;
   logic              q_we;
   logic [NODE_W-1:0] q_waddr, q_raddr;
   logic [NODE_W-1:0] q_wdata, q_rd;

   logic              accept;
   logic              out_free;
   logic              c_ok;
   logic [CHAR_W-1:0] c_idx;
   logic [CHAR_W-1:0] scan_idx;
   logic [NODE_W-1:0] kid_req;
   logic [NODE_W-1:0] kid_scan_u;
   logic [NODE_W-1:0] kid_scan_l;
   logic [FW-1:0]     depth_inc;
   logic [ROW_W-1:0]  row_ins;
   logic [NODE_W-1:0] sel_idx;
   logic              sel_ok;

   mpab_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_row_ram (
      .clock  (clock),
      .wr_en  (row_we),
      .wr_addr(row_waddr),
      .wr_data(row_wdata),
      .rd_addr(row_raddr),
      .rd_data(row_rd)
   );

   mpab_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock  (clock),
      .wr_en  (node_we),
      .wr_addr(node_waddr),
      .wr_data(node_wdata),
      .rd_addr(node_raddr),
      .rd_data(node_rd)
   );

   mpab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock  (clock),
      .wr_en  (q_we),
      .wr_addr(q_waddr),
      .wr_data(q_wdata),
      .rd_addr(q_raddr),
      .rd_data(q_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // request fields, taken live in idle and from the capture register afterwards
   always_comb begin
      mpab_pkg::req_type r;
      r = (state_ff == S_IDLE) ? req_data : req_ff;
      c_ok    = ({27'd0, r.char_code} < ALPHABET);
      c_idx   = CHAR_W'(r.char_code);
      sel_idx = NODE_W'(r.node_select);
      sel_ok  = (SEL_W'(r.node_select) < SEL_W'(used_ff));
   end

   assign scan_idx   = scan_ff[CHAR_W-1:0];
   assign kid_req    = row_rd[c_idx*NODE_W +: NODE_W];
   assign kid_scan_u = row_u_ff[scan_idx*NODE_W +: NODE_W];
   assign kid_scan_l = row_rd[scan_idx*NODE_W +: NODE_W];
   assign depth_inc  = (depth_ff != mpab_pkg::LEN_MAX) ? depth_ff + 1'b1 : depth_ff;

   always_comb begin
      row_ins = row_rd;
      row_ins[c_idx*NODE_W +: NODE_W] = used_ff[NODE_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      cursor_in   = cursor_ff;
      depth_in    = depth_ff;
      used_in     = used_ff;
      new_node_in = new_node_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      row_u_in    = row_u_ff;
      slu_has_in  = slu_has_ff;
      slu_in      = slu_ff;
      scan_in     = scan_ff;
      v_in        = v_ff;
      s_in        = s_ff;
      tl_has_in   = tl_has_ff;
      tl_in       = tl_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      row_we     = 1'b0;
      row_waddr  = '0;
      row_wdata  = '0;
      row_raddr  = cursor_ff;
      node_we    = 1'b0;
      node_waddr = '0;
      node_wdata = '0;
      node_raddr = '0;
      q_we       = 1'b0;
      q_waddr    = '0;
      q_wdata    = '0;
      q_raddr    = head_ff[NODE_W-1:0];

      case (state_ff)
         S_INIT: begin
            // root gets an empty row and a word with no links
            row_we    = 1'b1;
            node_we   = 1'b1;
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '0;
               case (req_data.op)
                  mpab_pkg::OP_CHAR: begin
                     if (c_ok) begin
                        row_raddr = cursor_ff;
                        state_in  = S_C_ROW;
                     end else begin
                        res_in.node_index = FW'(cursor_ff);
                        if (req_data.last_char) begin
                           cursor_in = '0;
                           depth_in  = '0;
                        end
                        state_in = S_EMIT;
                     end
                  end
                  mpab_pkg::OP_BUILD: begin
                     state_in = S_B_START;
                  end
                  mpab_pkg::OP_READ: begin
                     res_in.node_index = req_data.node_select;
                     if (sel_ok) begin
                        row_raddr  = sel_idx;
                        node_raddr = sel_idx;
                        state_in   = S_R_DATA;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_C_ROW: begin
            if (kid_req != '0) begin
               cursor_in         = kid_req;
               depth_in          = depth_inc;
               res_in.node_index = FW'(kid_req);
               if (req_ff.last_char) begin
                  node_raddr  = kid_req;
                  new_node_in = kid_req;
                  state_in    = S_C_TERM;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (used_ff == CNT_W'(MAX_NODES)) begin
               res_in.node_index = FW'(cursor_ff);
               res_in.table_full = 1'b1;
               if (req_ff.last_char) begin
                  cursor_in = '0;
                  depth_in  = '0;
               end
               state_in = S_EMIT;
            end else begin
               // allocate the next node and hang it under the cursor
               row_we     = 1'b1;
               row_waddr  = cursor_ff;
               row_wdata  = row_ins;
               node_we    = 1'b1;
               node_waddr = used_ff[NODE_W-1:0];
               node_wdata = '0;
               if (req_ff.last_char) begin
                  node_wdata[FLAG_BIT]  = 1'b1;
                  node_wdata[FW-1:0]    = depth_inc;
               end
               used_in           = used_ff + 1'b1;
               new_node_in       = used_ff[NODE_W-1:0];
               res_in.node_index = FW'(used_ff[NODE_W-1:0]);
               cursor_in         = req_ff.last_char ? '0 : used_ff[NODE_W-1:0];
               depth_in          = req_ff.last_char ? '0 : depth_inc;
               state_in          = S_C_CLR;
            end
         end
         S_C_CLR: begin
            row_we    = 1'b1;
            row_waddr = new_node_ff;
            row_wdata = '0;
            state_in  = S_EMIT;
         end
         S_C_TERM: begin
            node_we    = 1'b1;
            node_waddr = new_node_ff;
            node_wdata = node_rd;
            node_wdata[FLAG_BIT] = 1'b1;
            node_wdata[FW-1:0]   = depth_ff;
            cursor_in  = '0;
            depth_in   = '0;
            state_in   = S_EMIT;
         end
         S_R_DATA: begin
            res_in.has_suffix_link   = node_rd[SL_HAS];
            res_in.suffix_link       = node_rd[SL_HAS] ?
                                       FW'(node_rd[SL_LSB +: NODE_W]) : '0;
            res_in.has_terminal_link = node_rd[TL_HAS];
            res_in.terminal_link     = node_rd[TL_HAS] ?
                                       FW'(node_rd[TL_LSB +: NODE_W]) : '0;
            res_in.is_terminal       = node_rd[FLAG_BIT];
            res_in.pattern_length    = node_rd[FLAG_BIT] ? node_rd[FW-1:0] : '0;
            if (c_ok && (kid_req != '0)) begin
               res_in.child     = FW'(kid_req);
               res_in.has_child = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_B_START: begin
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = '0;
            head_in  = '0;
            tail_in  = CNT_W'(1);
            state_in = S_B_POP;
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               res_in.node_index = FW'(used_ff - 1'b1);
               state_in          = S_EMIT;
            end else begin
               q_raddr  = head_ff[NODE_W-1:0];
               head_in  = head_ff + 1'b1;
               state_in = S_B_U1;
            end
         end
         S_B_U1: begin
            row_raddr  = q_rd;
            node_raddr = q_rd;
            state_in   = S_B_U2;
         end
         S_B_U2: begin
            row_u_in   = row_rd;
            slu_has_in = node_rd[SL_HAS];
            slu_in     = node_rd[SL_LSB +: NODE_W];
            scan_in    = '0;
            state_in   = S_B_SCAN;
         end
         S_B_SCAN: begin
            if (scan_ff == SCAN_W'(ALPHABET)) begin
               state_in = S_B_POP;
            end else if (kid_scan_u == '0) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               v_in = kid_scan_u;
               if (!slu_has_ff) begin
                  s_in     = '0;
                  state_in = S_B_S;
               end else begin
                  row_raddr  = slu_ff;
                  node_raddr = slu_ff;
                  state_in   = S_B_L;
               end
            end
         end
         S_B_L: begin
            // walk the suffix chain until a node has a child on this letter or the chain ends
            if (kid_scan_l != '0) begin
               s_in     = kid_scan_l;
               state_in = S_B_S;
            end else if (!node_rd[SL_HAS]) begin
               s_in     = '0;
               state_in = S_B_S;
            end else begin
               row_raddr  = node_rd[SL_LSB +: NODE_W];
               node_raddr = node_rd[SL_LSB +: NODE_W];
            end
         end
         S_B_S: begin
            node_raddr = s_ff;
            state_in   = S_B_SD;
         end
         S_B_SD: begin
            if (node_rd[FLAG_BIT]) begin
               tl_has_in = 1'b1;
               tl_in     = s_ff;
            end else begin
               tl_has_in = node_rd[TL_HAS];
               tl_in     = node_rd[TL_LSB +: NODE_W];
            end
            node_raddr = v_ff;
            state_in   = S_B_V;
         end
         S_B_V: begin
            node_we    = 1'b1;
            node_waddr = v_ff;
            node_wdata = node_rd;
            node_wdata[SL_HAS]               = 1'b1;
            node_wdata[SL_LSB +: NODE_W]     = s_ff;
            node_wdata[TL_HAS]               = tl_has_ff;
            node_wdata[TL_LSB +: NODE_W]     = tl_ff;
            if (tail_ff < CNT_W'(MAX_NODES)) begin
               q_we    = 1'b1;
               q_waddr = tail_ff[NODE_W-1:0];
               q_wdata = v_ff;
               tail_in = tail_ff + 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = S_B_SCAN;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         depth_ff     <= '0;
         used_ff      <= CNT_W'(1);
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         depth_ff     <= depth_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      new_node_ff <= new_node_in;
      row_u_ff    <= row_u_in;
      slu_has_ff  <= slu_has_in;
      slu_ff      <= slu_in;
      scan_ff     <= scan_in;
      v_ff        <= v_in;
      s_ff        <= s_in;
      tl_has_ff   <= tl_has_in;
      tl_ff       <= tl_in;
   end

   // the cursor always names an allocated node
   a_cursor_alloc: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cursor_ff} < used_ff))
      else $error("cursor beyond allocated nodes");

   // node count stays between the root alone and a full table
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) && (used_ff <= CNT_W'(MAX_NODES)))
      else $error("node count out of range");

   // a new result transfer only starts out of the emit state
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result raised outside emit");

   // the breadth-first queue never pops past its tail nor grows past the node count
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_B_SCAN) |-> ((head_ff <= tail_ff) && (tail_ff <= used_ff)))
      else $error("queue pointers inconsistent");

   // a child write during insert always leaves the table one node larger
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (row_we && (state_ff == S_C_ROW)) |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("allocation without node count update");

endmodule
